/* design/cossim_pkg.sv */
// Shared types, widths and constants of the cosine similarity block.
package cossim_pkg;

  // Field and register widths.
  localparam int ELEM_W = 16;
  localparam int SIM_W  = 16;
  localparam int LEN_W  = 10;
  localparam logic [LEN_W-1:0] LEN_RESET = 10'd512;

  // Default upper bound on the vector length.
  localparam int DEF_MAX_DIM = 512;

  // Accumulator and arithmetic widths.
  localparam int PROD_AB_W = 2 * ELEM_W;      // signed a*b
  localparam int PROD_SQ_W = 2 * ELEM_W - 1;  // a*a, never above 2^30
  localparam int DOT_W     = 41;
  localparam int NORM_W    = 40;
  localparam int MAG_W     = 40;
  localparam int HALF_W    = MAG_W / 2;       // digit of the serial multiplier
  localparam int WIDE_W    = 2 * MAG_W;       // full 40x40 product
  localparam int REM_W     = WIDE_W + 1;      // division remainder before subtract
  localparam int QUO_W     = 31;              // quotient never above 2^30
  localparam int SQ_W      = 32;
  localparam int Q_W       = 16;              // root never above 2^15

  localparam logic [SQ_W-1:0] SQ_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic [SIM_W-1:0] SIM_POS_MAX = {1'b0, {(SIM_W-1){1'b1}}};

  // Step counts of the serial units.
  localparam int MUL_STEPS  = 4;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = Q_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       prod_load;   // input beat: register the element products
    logic       mul_clear;   // clear the product registers
    logic       mul_en;      // one partial product step
    logic       mul_sel;     // 0: norm product, 1: squared dot magnitude
    logic [1:0] mul_step;    // digit pair of the partial product
    logic       div_en;      // one quotient bit
    logic       div_first;   // first quotient bit, no shift
    logic       sqrt_en;     // one root bit
    logic       sqrt_first;  // first root bit, load the radicand
    logic       out_load;    // capture the result in the output register
    logic       acc_clear;   // clear the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_norm;
  } status_t;

endpackage

/* design/cossim_in_if.sv */
// Input channel: one element of each vector per beat.
interface cossim_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [cossim_pkg::ELEM_W-1:0]     elem_a;
  logic signed [cossim_pkg::ELEM_W-1:0]     elem_b;

  modport source(output valid, output elem_a, output elem_b, input ready);
  modport sink(input valid, input elem_a, input elem_b, output ready);
endinterface

/* design/cossim_out_if.sv */
// Result channel: one similarity value per comparison.
interface cossim_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [cossim_pkg::SIM_W-1:0]  similarity;
  logic                                 zero_norm;

  modport source(output valid, output similarity, output zero_norm, input ready);
  modport sink(input valid, input similarity, input zero_norm, output ready);
endinterface

/* design/cosine_similarity_core.sv */
// Top level of the cosine similarity block.
//
// Usage: each beat on in_ch carries one element of vector A and the element
// of vector B at the same index, both signed Q4.12. The block takes one beat
// per cycle until the count reaches the vector length in cfg_wr_data (written
// with cfg_wr_en while idle; zero counts as one, values above MAX_DIM as
// MAX_DIM). After the last beat in_ch.ready stays low while the result is
// formed: the product stage, a check, the 20x20 partial products, the
// divider, the square root and the load of the output register; when a norm
// is zero the check leads straight to the load. out_ch carries the
// similarity in Q1.15, saturated at +/-1.0, with zero_norm set and a zero
// value when either norm is zero.
// While out_ch is stalled the output register holds and the next vector is
// accepted; only a second finished result waits for the register to empty.
// Synchronous reset clears the accumulators, the count and the output valid,
// and sets the vector length to 512.
module cosine_similarity_core #(
  parameter int MAX_DIM = cossim_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cossim_pkg::LEN_W-1:0]  cfg_wr_data,
  cossim_in_if.sink                     in_ch,
  cossim_out_if.source                  out_ch
);

  cossim_pkg::cmd_t    cmd;
  cossim_pkg::status_t status;

  // Sequencing and count.
  cossim_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Arithmetic.
  cossim_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .elem_a     (in_ch.elem_a),
    .elem_b     (in_ch.elem_b),
    .similarity (out_ch.similarity),
    .zero_norm  (out_ch.zero_norm)
  );

endmodule

/* design/cossim_ctrl.sv */
// Controller: element count, vector length register and sequencing of the final steps.
module cossim_ctrl #(
  parameter int MAX_DIM = cossim_pkg::DEF_MAX_DIM
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [cossim_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  cossim_pkg::status_t           status,
  output cossim_pkg::cmd_t              cmd
);

  localparam int LenW = cossim_pkg::LEN_W;
  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int CmpW = (DimW > LenW) ? DimW : LenW;
  localparam int StepW = cossim_pkg::STEP_W;

  localparam logic [StepW-1:0] MulLast  = StepW'(cossim_pkg::MUL_STEPS - 1);
  localparam logic [StepW-1:0] DivLast  = StepW'(cossim_pkg::DIV_STEPS - 1);
  localparam logic [StepW-1:0] SqrtLast = StepW'(cossim_pkg::SQRT_STEPS - 1);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_DRAIN = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MULP  = 3'd3;
  localparam logic [2:0] S_MULM  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_SQRT  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [LenW-1:0]  count_r, count_nxt;
  logic [LenW-1:0]  vlen_r;
  logic             out_valid_r, out_valid_nxt;

  logic [LenW-1:0]  count_inc;
  logic [CmpW-1:0]  vlen_ext;
  logic [CmpW-1:0]  eff_len;
  logic             beat;
  logic             last_elem;
  logic             out_free;

  assign in_ready  = (state_r == S_ACC);
  assign out_valid = out_valid_r;
  assign beat      = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Effective length: zero counts as one, anything above the bound as the bound.
  always_comb begin
    vlen_ext = CmpW'(vlen_r);
    if (vlen_ext == '0) begin
      eff_len = CmpW'(1);
    end else if (vlen_ext > CmpW'(MAX_DIM)) begin
      eff_len = CmpW'(MAX_DIM);
    end else begin
      eff_len = vlen_ext;
    end
  end

  // The count wraps in its own width; a wrap also closes the vector.
  assign count_inc = count_r + LenW'(1);
  assign last_elem = (count_inc == '0) || (CmpW'(count_inc) >= eff_len);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    cmd       = '0;
    cmd.prod_load = beat;
    unique case (state_r)
      S_ACC: begin
        if (beat) begin
          count_nxt = last_elem ? '0 : count_inc;
          if (last_elem) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.mul_clear = 1'b1;
        step_nxt      = '0;
        state_nxt     = status.zero_norm ? S_DONE : S_MULP;
      end
      S_MULP: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = 1'b0;
        cmd.mul_step = step_r[1:0];
        if (step_r == MulLast) begin
          step_nxt  = '0;
          state_nxt = S_MULM;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      S_MULM: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = 1'b1;
        cmd.mul_step = step_r[1:0];
        if (step_r == MulLast) begin
          step_nxt  = '0;
          state_nxt = S_DIV;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      S_DIV: begin
        cmd.div_en    = 1'b1;
        cmd.div_first = (step_r == '0);
        if (step_r == DivLast) begin
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      S_SQRT: begin
        cmd.sqrt_en    = 1'b1;
        cmd.sqrt_first = (step_r == '0);
        if (step_r == SqrtLast) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + StepW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.acc_clear = 1'b1;
          state_nxt     = S_ACC;
        end
      end
    endcase
  end

  // Output valid is set by a load and held until the receiver takes the beat.
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      step_r      <= '0;
      count_r     <= '0;
      vlen_r      <= cossim_pkg::LEN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        vlen_r <= cfg_wr_data;
      end
    end
  end

endmodule

/* design/cossim_dpath.sv */
// Datapath: product stage, accumulators, serial multiplier, divider, square root, output register.
module cossim_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cossim_pkg::cmd_t                     cmd,
  output cossim_pkg::status_t                  status,
  input  logic signed [cossim_pkg::ELEM_W-1:0] elem_a,
  input  logic signed [cossim_pkg::ELEM_W-1:0] elem_b,
  output logic signed [cossim_pkg::SIM_W-1:0]  similarity,
  output logic                                 zero_norm
);

  localparam int HalfW = cossim_pkg::HALF_W;
  localparam int WideW = cossim_pkg::WIDE_W;
  localparam int RemW  = cossim_pkg::REM_W;
  localparam int QuoW  = cossim_pkg::QUO_W;
  localparam int SqW   = cossim_pkg::SQ_W;
  localparam int QW    = cossim_pkg::Q_W;
  localparam int SimW  = cossim_pkg::SIM_W;

  // Product stage.
  logic                                      prod_vld_r;
  logic signed [cossim_pkg::PROD_AB_W-1:0]   p_ab_r;
  logic [cossim_pkg::PROD_SQ_W-1:0]          p_aa_r;
  logic [cossim_pkg::PROD_SQ_W-1:0]          p_bb_r;
  logic signed [cossim_pkg::PROD_AB_W-1:0]   p_ab_nxt, p_aa_full, p_bb_full;

  // Accumulators.
  logic signed [cossim_pkg::DOT_W-1:0]       dot_r;
  logic [cossim_pkg::NORM_W-1:0]             na_r;
  logic [cossim_pkg::NORM_W-1:0]             nb_r;

  // Serial multiplier and divider operands.
  logic [WideW-1:0]                          divisor_r;
  logic [RemW-1:0]                           rem_r;
  logic [QuoW-1:0]                           quo_r;
  logic [SqW-1:0]                            sq_num_r, sq_res_r, sq_bit_r;
  logic signed [SimW-1:0]                    sim_r;
  logic                                      zero_r;

  logic                                      dot_neg;
  logic [cossim_pkg::DOT_W-1:0]              dot_abs;
  logic [cossim_pkg::MAG_W-1:0]              mag;
  logic [cossim_pkg::MAG_W-1:0]              mul_x, mul_y;
  logic [HalfW-1:0]                          x_dig, y_dig;
  logic [2*HalfW-1:0]                        pp;
  logic [WideW-1:0]                          pp_ext, pp_sh, mul_base, mul_sum;
  logic [RemW-1:0]                           div_shift, div_dvs, rem_nxt;
  logic                                      div_ge;
  logic [SqW-1:0]                            num_cur, res_cur, bit_cur, trial;
  logic [SqW-1:0]                            sq_num_nxt, sq_res_nxt;
  logic [QW-1:0]                             root;
  logic signed [SimW-1:0]                    sim_nxt;
  logic                                      zero_now;

  // Element products.
  assign p_ab_nxt  = elem_a * elem_b;
  assign p_aa_full = elem_a * elem_a;
  assign p_bb_full = elem_b * elem_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.prod_load;
    end
    if (cmd.prod_load) begin
      p_ab_r <= p_ab_nxt;
      p_aa_r <= p_aa_full[cossim_pkg::PROD_SQ_W-1:0];
      p_bb_r <= p_bb_full[cossim_pkg::PROD_SQ_W-1:0];
    end
  end

  // Accumulate one product set per cycle; clear when the result is loaded into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.acc_clear) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else if (prod_vld_r) begin
      dot_r <= dot_r + cossim_pkg::DOT_W'(p_ab_r);
      na_r  <= na_r + cossim_pkg::NORM_W'(p_aa_r);
      nb_r  <= nb_r + cossim_pkg::NORM_W'(p_bb_r);
    end
  end

  // Sign and magnitude of the dot product; the magnitude always fits 40 bits.
  assign dot_neg  = dot_r[cossim_pkg::DOT_W-1];
  assign dot_abs  = dot_neg ? (~dot_r + 1'b1) : dot_r;
  assign mag      = dot_abs[cossim_pkg::MAG_W-1:0];
  assign zero_now = (na_r == '0) || (nb_r == '0);
  assign status.zero_norm = zero_now;

  // Serial multiplier: one 20x20 partial product per cycle.
  assign mul_x = cmd.mul_sel ? mag : na_r;
  assign mul_y = cmd.mul_sel ? mag : nb_r;
  assign x_dig = cmd.mul_step[1] ? mul_x[2*HalfW-1:HalfW] : mul_x[HalfW-1:0];
  assign y_dig = cmd.mul_step[0] ? mul_y[2*HalfW-1:HalfW] : mul_y[HalfW-1:0];
  assign pp     = x_dig * y_dig;
  assign pp_ext = WideW'(pp);

  always_comb begin
    unique case (cmd.mul_step)
      2'b00:        pp_sh = pp_ext;
      2'b01, 2'b10: pp_sh = pp_ext << HalfW;
      2'b11:        pp_sh = pp_ext << (2 * HalfW);
    endcase
  end

  assign mul_base = cmd.mul_sel ? rem_r[WideW-1:0] : divisor_r;
  assign mul_sum  = mul_base + pp_sh;

  // Restoring division of the squared magnitude times 2^30 by the norm product.
  assign div_shift = cmd.div_first ? rem_r : {rem_r[RemW-2:0], 1'b0};
  assign div_dvs   = RemW'(divisor_r);
  assign div_ge    = (div_shift >= div_dvs);
  assign rem_nxt   = div_ge ? (div_shift - div_dvs) : div_shift;

  always_ff @(posedge clk) begin
    if (cmd.mul_clear) begin
      divisor_r <= '0;
      rem_r     <= '0;
    end else if (cmd.mul_en) begin
      if (cmd.mul_sel) begin
        rem_r <= RemW'(mul_sum);
      end else begin
        divisor_r <= mul_sum;
      end
    end else if (cmd.div_en) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[QuoW-2:0], div_ge};
    end
  end

  // Integer square root of the quotient, one result bit per cycle.
  assign num_cur = cmd.sqrt_first ? SqW'(quo_r) : sq_num_r;
  assign res_cur = cmd.sqrt_first ? '0 : sq_res_r;
  assign bit_cur = cmd.sqrt_first ? cossim_pkg::SQ_BIT_INIT : sq_bit_r;
  assign trial   = res_cur + bit_cur;

  always_comb begin
    if (num_cur >= trial) begin
      sq_num_nxt = num_cur - trial;
      sq_res_nxt = (res_cur >> 1) + bit_cur;
    end else begin
      sq_num_nxt = num_cur;
      sq_res_nxt = res_cur >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_en) begin
      sq_num_r <= sq_num_nxt;
      sq_res_r <= sq_res_nxt;
      sq_bit_r <= bit_cur >> 2;
    end
  end

  // Sign, saturation at +1.0 and the zero norm case.
  assign root = sq_res_r[QW-1:0];

  always_comb begin
    if (zero_now) begin
      sim_nxt = '0;
    end else if (dot_neg) begin
      sim_nxt = SimW'(~root + 1'b1);
    end else if (root > QW'(cossim_pkg::SIM_POS_MAX)) begin
      sim_nxt = cossim_pkg::SIM_POS_MAX;
    end else begin
      sim_nxt = SimW'(root);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sim_r  <= sim_nxt;
      zero_r <= zero_now;
    end
  end

  assign similarity = sim_r;
  assign zero_norm  = zero_r;

endmodule

/* design/cossim_checker.sv */
// Port-level checks of the cosine similarity block and their binding.
module cossim_port_checks (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [cossim_pkg::SIM_W-1:0]  similarity,
  input logic                                 zero_norm
);

  // A zero norm result always carries a zero similarity.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_norm |-> similarity == '0)
    else $error("zero norm result with nonzero similarity");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(similarity) && $stable(zero_norm))
    else $error("stalled result beat changed");

  // A new result only follows a cycle in which the input was closed.
  a_result_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while input was open");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input only closes after it has taken a beat.
  a_close_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_ready))
    else $error("input closed without a beat");

endmodule

bind cosine_similarity_core cossim_port_checks u_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .similarity (out_ch.similarity),
  .zero_norm  (out_ch.zero_norm)
);

/* bench/cossim_checker.sv */
// Checker for the cosine similarity block: predicts every result and compares it.
module cossim_checker #(
  parameter int MAX_DIM = cossim_pkg::DEF_MAX_DIM
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cossim_pkg::LEN_W-1:0] cfg_wr_data,
  cossim_in_if                         in_ch,
  cossim_out_if                        out_ch,
  output int                           errors,
  output int                           pending,
  output int                           results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [cossim_pkg::SIM_W-1:0] similarity;
    logic                                zero_norm;
  } sim_result_t;

  // Shadow of the block's register and accumulators.
  logic        [cossim_pkg::LEN_W-1:0]  vec_len;
  logic        [cossim_pkg::LEN_W-1:0]  elem_cnt;
  logic signed [cossim_pkg::DOT_W-1:0]  dot_sum;
  logic        [cossim_pkg::NORM_W-1:0] norm_a_sum;
  logic        [cossim_pkg::NORM_W-1:0] norm_b_sum;
  sim_result_t                          sim_expected[$];
  int                                   err_cnt = 0;
  int                                   seen_cnt = 0;

  // Exact cosine: largest q with q^2 * na * nb <= dot^2 * 2^30, signed and saturated.
  function automatic sim_result_t cosine_q15(
      input logic signed [cossim_pkg::DOT_W-1:0] dot,
      input logic [cossim_pkg::NORM_W-1:0]       na,
      input logic [cossim_pkg::NORM_W-1:0]       nb);
    logic signed [cossim_pkg::DOT_W-1:0] abs_dot;
    logic [127:0]                        mag;
    logic [127:0]                        bound;
    logic [127:0]                        lhs;
    logic [127:0]                        mid_w;
    int                                  lo;
    int                                  hi;
    int                                  mid;
    sim_result_t                         res;
    res.similarity = '0;
    res.zero_norm  = 1'b0;
    if (na == 0 || nb == 0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    abs_dot = (dot < 0) ? -dot : dot;
    mag     = 128'(unsigned'(abs_dot));
    bound   = (mag * mag) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid   = (lo + hi + 1) / 2;
      mid_w = 128'(mid);
      lhs   = mid_w * mid_w * 128'(na) * 128'(nb);
      if (lhs <= bound) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    if (dot < 0) begin
      res.similarity = cossim_pkg::SIM_W'(-lo);
    end else begin
      res.similarity = cossim_pkg::SIM_W'((lo > 32767) ? 32767 : lo);
    end
    return res;
  endfunction

  // One pass per clock edge: result beat first, then config, then input beat.
  always @(posedge clk) begin
    logic signed [cossim_pkg::PROD_AB_W-1:0] p_ab;
    logic signed [cossim_pkg::PROD_AB_W-1:0] p_aa;
    logic signed [cossim_pkg::PROD_AB_W-1:0] p_bb;
    int                                      eff_len;
    sim_result_t                             exp_res;
    if (!rst_n) begin
      vec_len    = cossim_pkg::LEN_RESET;
      elem_cnt   = '0;
      dot_sum    = '0;
      norm_a_sum = '0;
      norm_b_sum = '0;
      sim_expected.delete();
    end else begin
      // Compare a result beat with the oldest prediction.
      if (out_ch.valid && out_ch.ready) begin
        seen_cnt++;
        if (sim_expected.size() == 0) begin
          $error("unexpected result beat: similarity %0d, zero_norm %0b",
                 out_ch.similarity, out_ch.zero_norm);
          err_cnt++;
        end else begin
          exp_res = sim_expected.pop_front();
          if (out_ch.similarity !== exp_res.similarity) begin
            $error("similarity mismatch: expected %0d, actual %0d",
                   exp_res.similarity, out_ch.similarity);
            err_cnt++;
          end
          if (out_ch.zero_norm !== exp_res.zero_norm) begin
            $error("zero_norm mismatch: expected %0b, actual %0b",
                   exp_res.zero_norm, out_ch.zero_norm);
            err_cnt++;
          end
        end
      end

      if (cfg_wr_en) begin
        vec_len = cfg_wr_data;
      end

      // Accumulate an element beat and predict the result when the vector ends.
      if (in_ch.valid && in_ch.ready) begin
        p_ab       = in_ch.elem_a * in_ch.elem_b;
        p_aa       = in_ch.elem_a * in_ch.elem_a;
        p_bb       = in_ch.elem_b * in_ch.elem_b;
        dot_sum    = dot_sum + cossim_pkg::DOT_W'(p_ab);
        norm_a_sum = norm_a_sum + cossim_pkg::NORM_W'(unsigned'(p_aa));
        norm_b_sum = norm_b_sum + cossim_pkg::NORM_W'(unsigned'(p_bb));
        elem_cnt   = elem_cnt + 1'b1;
        eff_len    = (vec_len == 0) ? 1 : ((vec_len > MAX_DIM) ? MAX_DIM : int'(vec_len));
        if (elem_cnt == 0 || elem_cnt >= eff_len) begin
          sim_expected = {sim_expected, cosine_q15(dot_sum, norm_a_sum, norm_b_sum)};
          dot_sum    = '0;
          norm_a_sum = '0;
          norm_b_sum = '0;
          elem_cnt   = '0;
        end
      end
    end
    errors       <= err_cnt;
    pending      <= sim_expected.size();
    results_seen <= seen_cnt;
  end

endmodule

/* bench/testbench.sv */
// Top of the cosine similarity bench: clock, reset, stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RxHoldLen = 300;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [cossim_pkg::LEN_W-1:0] cfg_wr_data;

  cossim_in_if  in_ch();
  cossim_out_if out_ch();

  int fail_count;
  int pending;
  int results_seen;
  int beats_sent;
  int lengths_written;
  int phase;
  int rnd;
  int len;
  bit tx_calm;
  bit rx_calm;
  int hold_requests;

  cosine_similarity_core #(.MAX_DIM(cossim_pkg::DEF_MAX_DIM)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  cossim_checker #(.MAX_DIM(cossim_pkg::DEF_MAX_DIM)) sim_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .errors       (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random back-pressure, a calm mode and a counted long hold-off.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = RxHoldLen;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 26);
      end
    end
  end

  // Offer one element beat and hold it until accepted; sometimes idle after.
  task automatic send_beat(input logic [cossim_pkg::ELEM_W-1:0] a,
                           input logic [cossim_pkg::ELEM_W-1:0] b);
    in_ch.valid  <= 1'b1;
    in_ch.elem_a <= a;
    in_ch.elem_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    if (!tx_calm && $urandom_range(99) < 18) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Stop offering beats and wait until every predicted result has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Change the vector length once the block has gone quiet.
  task automatic write_length(input logic [cossim_pkg::LEN_W-1:0] value);
    drain();
    repeat (70) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lengths_written++;
  endtask

  // One vector pair of n elements with content of a randomly chosen kind.
  task automatic send_random_vector(input int n);
    logic [cossim_pkg::ELEM_W-1:0] a;
    logic [cossim_pkg::ELEM_W-1:0] b;
    int                            mode;
    mode = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      a = cossim_pkg::ELEM_W'($urandom);
      b = cossim_pkg::ELEM_W'($urandom);
      case (mode)
        1: b = a;
        2: b = -a;
        3: b = a + cossim_pkg::ELEM_W'($urandom_range(0, 63)) - cossim_pkg::ELEM_W'(32);
        4: begin
          a = cossim_pkg::ELEM_W'($urandom_range(0, 16)) - cossim_pkg::ELEM_W'(8);
          b = cossim_pkg::ELEM_W'($urandom_range(0, 16)) - cossim_pkg::ELEM_W'(8);
        end
        5: a = '0;
        6: begin
          if ($urandom_range(3) != 0) a = '0;
          if ($urandom_range(3) != 0) b = '0;
        end
        default: ;
      endcase
      send_beat(a, b);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.elem_a <= '0;
    in_ch.elem_b <= '0;
    beats_sent      = 0;
    lengths_written = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Single-element vectors: saturation both ways, zero norms, field extremes.
    write_length(10'd1);
    send_beat(16'h7FFF, 16'h7FFF);
    send_beat(16'h8000, 16'h8000);
    send_beat(16'h8000, 16'h7FFF);
    send_beat(16'h7FFF, 16'h8000);
    send_beat(16'h0000, 16'h0005);
    send_beat(16'hFFFB, 16'h0000);
    send_beat(16'h0000, 16'h0000);
    send_beat(16'h0001, 16'hFFFF);
    send_beat(16'h1000, 16'h0800);

    // A length of zero behaves like a length of one.
    write_length(10'd0);
    send_beat(16'h1234, 16'hEDCC);
    send_beat(16'h0001, 16'h0003);

    // Three elements with partial correlation.
    write_length(10'd3);
    send_beat(16'h1000, 16'h0000);
    send_beat(16'h0000, 16'h1000);
    send_beat(16'h8000, 16'hFFFF);

    // Length lowered below the count mid-vector: the next element completes it.
    write_length(10'd8);
    send_beat(16'h0123, 16'h0456);
    send_beat(16'hF800, 16'h0700);
    send_beat(16'h7FFF, 16'h0001);
    send_beat(16'h0042, 16'hFF00);
    send_beat(16'hABCD, 16'h5432);
    write_length(10'd2);
    send_beat(16'h0800, 16'h0800);

    // Random phases, each under its own vector length.
    phase = 0;
    while (beats_sent < 1500) begin
      phase++;
      if (phase == 3) begin
        // Register maximum, clipped to the largest dimension.
        write_length(10'h3FF);
        send_random_vector(cossim_pkg::DEF_MAX_DIM);
      end else if (phase == 6) begin
        // Results held off for a long stretch while beats are still offered.
        write_length(10'd1);
        tx_calm = 1'b1;
        hold_requests++;
        repeat (30) send_random_vector(1);
        tx_calm = 1'b0;
      end else if (phase == 9) begin
        // Neither side idles here.
        write_length(cossim_pkg::LEN_W'($urandom_range(4, 16)));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (12) send_random_vector(8);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
      end else begin
        rnd = $urandom_range(99);
        if (rnd < 8) begin
          len = 0;
        end else if (rnd < 70) begin
          len = $urandom_range(1, 12);
        end else if (rnd < 92) begin
          len = $urandom_range(13, 64);
        end else begin
          len = $urandom_range(65, 200);
        end
        write_length(cossim_pkg::LEN_W'(len));
        repeat ($urandom_range(2, 8)) send_random_vector((len == 0) ? 1 : len);
      end
    end

    drain();
    repeat (80) @(posedge clk);

    $display("Covered %0d element beats under %0d length settings, 0, 1 and 1023 among them;",
             beats_sent, lengths_written);
    $display("%0d similarity results compared, with saturated and zero-norm vectors included.",
             results_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cossim_pkg.sv
design/cossim_in_if.sv
design/cossim_out_if.sv
design/cossim_ctrl.sv
design/cossim_dpath.sv
design/cosine_similarity_core.sv
design/cossim_checker.sv
bench/cossim_checker.sv
bench/testbench.sv
